### hw/rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int NUM_CELLS = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int SIZE_W = 9;
  localparam int SQ_W = 2 * COLOR_W;
  localparam int DIST_W = SQ_W + 2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               mode;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               have;
    logic [DIST_W-1:0]  best_dist;
    logic [INDEX_W-1:0] best_index;
  } npc_item_t;

endpackage

`default_nettype wire

### hw/rtl/npc_req_if.sv
// ----------------------------------------------------------------------------
// npc_req_if
// Request channel: palette loads and pixel lookups.
// ----------------------------------------------------------------------------
`default_nettype none

interface npc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [npc_pkg::INDEX_W-1:0] entry_index;
  logic [npc_pkg::COLOR_W-1:0] red;
  logic [npc_pkg::COLOR_W-1:0] green;
  logic [npc_pkg::COLOR_W-1:0] blue;

  modport source (output valid, mode, entry_index, red, green, blue, input ready);
  modport sink (input valid, mode, entry_index, red, green, blue, output ready);
endinterface

`default_nettype wire

### hw/rtl/npc_rsp_if.sv
// ----------------------------------------------------------------------------
// npc_rsp_if
// Response channel: nearest palette entry for one lookup.
// ----------------------------------------------------------------------------
`default_nettype none

interface npc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [npc_pkg::INDEX_W-1:0] nearest_index;
  logic                        exact_match;

  modport source (output valid, found, nearest_index, exact_match, input ready);
  modport sink (input valid, found, nearest_index, exact_match, output ready);
endinterface

`default_nettype wire

### hw/rtl/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell
// One palette entry: stores it, computes the distance to a passing pixel and
// keeps the running best in the item handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic [npc_pkg::SIZE_W-1:0]  palette_size,
  input  wire logic [npc_pkg::INDEX_W-1:0] cell_index,
  input  wire npc_pkg::npc_item_t          upstream,
  output npc_pkg::npc_item_t               downstream
);

  function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
    input logic [npc_pkg::COLOR_W-1:0] a,
    input logic [npc_pkg::COLOR_W-1:0] b
  );
    logic [npc_pkg::COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
  endfunction

  logic [npc_pkg::COLOR_W-1:0] entry_red;
  logic [npc_pkg::COLOR_W-1:0] entry_green;
  logic [npc_pkg::COLOR_W-1:0] entry_blue;

  npc_pkg::npc_item_t        stage;
  logic [npc_pkg::SQ_W-1:0]  sq_red;
  logic [npc_pkg::SQ_W-1:0]  sq_green;
  logic [npc_pkg::SQ_W-1:0]  sq_blue;

  npc_pkg::npc_item_t        result;
  npc_pkg::npc_item_t        result_next;
  logic [npc_pkg::DIST_W-1:0] distance;
  logic                       searched;

  always_ff @(posedge clk) begin
    if (advance && upstream.valid && upstream.mode == npc_pkg::MODE_LOAD &&
        upstream.entry_index == cell_index) begin
      entry_red   <= upstream.red;
      entry_green <= upstream.green;
      entry_blue  <= upstream.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage    <= upstream;
      sq_red   <= sq_diff(upstream.red, entry_red);
      sq_green <= sq_diff(upstream.green, entry_green);
      sq_blue  <= sq_diff(upstream.blue, entry_blue);
    end
  end

  always_comb begin
    distance = npc_pkg::DIST_W'(sq_red) + npc_pkg::DIST_W'(sq_green) +
               npc_pkg::DIST_W'(sq_blue);
    searched = stage.valid && stage.mode == npc_pkg::MODE_LOOKUP &&
               ({1'b0, cell_index} < palette_size);
    result_next = stage;
    if (searched && (!stage.have || distance < stage.best_dist)) begin
      result_next.have       = 1'b1;
      result_next.best_dist  = distance;
      result_next.best_index = cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result <= result_next;
    end
  end

  assign downstream = result;

endmodule

`default_nettype wire

### hw/rtl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Maps RGB pixels to the nearest loaded palette entry by squared distance,
// using a chain of cells with one palette entry per cell.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req       in         mode, entry_index, red, green, blue
//   rsp       out        found, nearest_index, exact_match (lookups only)
//   cfg       in         palette_size write
//
// One item enters per cycle while the response register is free or taken.
// A lookup result passes through two pipeline stages per cell plus the
// response register.
// Loads travel the same chain, so they keep their order with lookups.
// A waiting response halts the whole chain and holds req.ready low.
// Reset clears the pipeline and palette_size; palette entries are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search (
  input  wire logic                       clk,
  input  wire logic                       rst,
  npc_req_if.sink                         req,
  npc_rsp_if.source                       rsp,
  input  wire logic                       cfg_write_enable,
  input  wire logic [npc_pkg::SIZE_W-1:0] cfg_write_data
);

  logic [npc_pkg::SIZE_W-1:0] palette_size;
  logic                       advance;
  logic                       rsp_valid;
  logic                       found;
  logic [npc_pkg::INDEX_W-1:0] nearest_index;
  logic                       exact_match;

  npc_pkg::npc_item_t chain [npc_pkg::NUM_CELLS+1];
  npc_pkg::npc_item_t last;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
    end else if (cfg_write_enable) begin
      palette_size <= cfg_write_data;
    end
  end

  assign advance = !rsp_valid || rsp.ready;
  assign req.ready = advance;

  always_comb begin
    chain[0].valid       = req.valid;
    chain[0].mode        = req.mode;
    chain[0].entry_index = req.entry_index;
    chain[0].red         = req.red;
    chain[0].green       = req.green;
    chain[0].blue        = req.blue;
    chain[0].have        = 1'b0;
    chain[0].best_dist   = '0;
    chain[0].best_index  = '0;
  end

  for (genvar i = 0; i < npc_pkg::NUM_CELLS; i++) begin : g_cell
    npc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .palette_size (palette_size),
      .cell_index   (npc_pkg::INDEX_W'(i)),
      .upstream     (chain[i]),
      .downstream   (chain[i+1])
    );
  end

  assign last = chain[npc_pkg::NUM_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid     <= last.valid && last.mode == npc_pkg::MODE_LOOKUP;
      found         <= last.have;
      nearest_index <= last.have ? last.best_index : '0;
      exact_match   <= last.have && last.best_dist == '0;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.found         = found;
  assign rsp.nearest_index = nearest_index;
  assign rsp.exact_match   = exact_match;

endmodule

`default_nettype wire

### hw/rtl/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nearest palette color search.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic                        found,
  input wire logic [npc_pkg::INDEX_W-1:0] nearest_index,
  input wire logic                        exact_match
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) &&
    $stable(nearest_index) && $stable(exact_match))
    else $error("A waiting response item changed.");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("A request item was taken while a response item waited.");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> nearest_index == '0 && !exact_match)
    else $error("A not-found response carries an index or a match.");

  a_exact: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && exact_match |-> found)
    else $error("An exact match was reported without a found entry.");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("A response item appeared right after reset.");

endmodule

bind nearest_palette_color_search npc_checker u_npc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .found         (rsp.found),
  .nearest_index (rsp.nearest_index),
  .exact_match   (rsp.exact_match)
);

`default_nettype wire

### dv/nearest_palette_color_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search_tb
// Self-checking bench for the nearest palette color search. A short table of
// loads, lookups and palette_size writes runs first. A full palette fill with
// lookups and random phases at several palette sizes follows. Every lookup
// result is compared with a typed table result or a behavioral nearest-color
// search over a shadow copy of the palette. Both channels idle at random, and
// the response side holds off once for a long stretch to back the chain up.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_tb;

  localparam int DRAIN_CYCLES = 2 * npc_pkg::NUM_CELLS + 16;
  localparam int DIRECTED_ROWS = 21;
  localparam int PHASE_ITEMS = 50;
  localparam int LONG_HOLD = 700;
  localparam int HOLD_AFTER = 60;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [npc_pkg::COLOR_W-1:0] red;
    logic [npc_pkg::COLOR_W-1:0] green;
    logic [npc_pkg::COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                        found;
    logic [npc_pkg::INDEX_W-1:0] nearest_index;
    logic                        exact_match;
  } nearest_t;

  typedef enum logic {ROW_CONFIG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic                        mode;
    logic [npc_pkg::INDEX_W-1:0] entry_index;
    rgb_t                        color;
    logic [npc_pkg::SIZE_W-1:0]  palette_size;
    logic                        typed;
    nearest_t                    result;
  } step_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_enable;
  logic [npc_pkg::SIZE_W-1:0] cfg_write_data;

  npc_req_if req_ch ();
  npc_rsp_if rsp_ch ();

  nearest_palette_color_search dut (
    .clk              (clk),
    .rst              (rst),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  rgb_t                       palette_shadow [npc_pkg::PALETTE_DEPTH];
  logic [npc_pkg::SIZE_W-1:0] size_shadow = '0;
  nearest_t                   pending_results [$];
  step_row_t                  directed_rows [DIRECTED_ROWS];

  int mismatch_count = 0;
  int items_sent = 0;
  int responses_seen = 0;
  int load_count = 0;
  int lookup_count = 0;
  int exact_count = 0;
  int empty_count = 0;
  int size_writes = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_gap(int n);
    return (n % 64 < 12) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic int searched_entries();
    int n;
    n = int'(size_shadow);
    if (n > npc_pkg::NUM_CELLS) n = npc_pkg::NUM_CELLS;
    return n;
  endfunction

  function automatic rgb_t random_color();
    logic [31:0] bits;
    bits = $urandom;
    return bits[3*npc_pkg::COLOR_W-1:0];
  endfunction

  function automatic nearest_t find_nearest(rgb_t px);
    nearest_t res;
    int       n, dr, dg, db, distance, best;
    res = '0;
    best = 0;
    n = searched_entries();
    for (int i = 0; i < n; i++) begin
      dr = int'(palette_shadow[i].red) - int'(px.red);
      dg = int'(palette_shadow[i].green) - int'(px.green);
      db = int'(palette_shadow[i].blue) - int'(px.blue);
      distance = dr * dr + dg * dg + db * db;
      if (!res.found || distance < best) begin
        res.found = 1'b1;
        res.nearest_index = i[npc_pkg::INDEX_W-1:0];
        best = distance;
      end
    end
    res.exact_match = res.found && (best == 0);
    return res;
  endfunction

  function automatic rgb_t pick_pixel();
    int   n, sel;
    rgb_t px;
    n = searched_entries();
    sel = $urandom_range(0, 9);
    px = random_color();
    if (n > 0 && sel < 3) begin
      px = palette_shadow[$urandom_range(0, n - 1)];
      if (sel == 2) px.blue = px.blue ^ 8'h01;
    end else if (sel == 3) begin
      px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
      px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
      px.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end
    return px;
  endfunction

  task automatic send_item(input logic mode, input logic [npc_pkg::INDEX_W-1:0] idx,
                           input rgb_t px, input logic typed,
                           input nearest_t typed_result);
    int       gap;
    nearest_t result;
    gap = draw_gap(items_sent);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.entry_index <= idx;
    req_ch.red <= px.red;
    req_ch.green <= px.green;
    req_ch.blue <= px.blue;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (mode == npc_pkg::MODE_LOAD) begin
      load_count++;
      if (idx < npc_pkg::PALETTE_DEPTH) palette_shadow[idx] = px;
    end else begin
      result = typed ? typed_result : find_nearest(px);
      pending_results.push_back(result);
      lookup_count++;
      if (result.exact_match) exact_count++;
      if (!result.found) empty_count++;
    end
  endtask

  task automatic settle_block();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_size(input logic [npc_pkg::SIZE_W-1:0] value);
    settle_block();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    size_shadow = value;
    size_writes++;
  endtask

  initial begin : response_sink
    int       stall;
    bit       held;
    nearest_t due;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && responses_seen == HOLD_AFTER) begin
        held = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = draw_gap(responses_seen);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      responses_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("Unexpected result: found=%0b nearest_index=%0d exact_match=%0b",
                   rsp_ch.found, rsp_ch.nearest_index, rsp_ch.exact_match);
        end
      end else begin
        due = pending_results.pop_front();
        if (rsp_ch.found !== due.found || rsp_ch.nearest_index !== due.nearest_index ||
            rsp_ch.exact_match !== due.exact_match) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Result %0d: expected found=%0b nearest_index=%0d exact_match=%0b,",
                     responses_seen, due.found, due.nearest_index, due.exact_match);
            $display("  got found=%0b nearest_index=%0d exact_match=%0b",
                     rsp_ch.found, rsp_ch.nearest_index, rsp_ch.exact_match);
          end
        end
      end
    end
  end

  initial begin : stimulus
    step_row_t                  row;
    rgb_t                       color;
    int                         fill_order [npc_pkg::PALETTE_DEPTH];
    int                         j, tmp;
    logic [npc_pkg::SIZE_W-1:0] phase_sizes [8];

    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = npc_pkg::MODE_LOAD;
    req_ch.entry_index = '0;
    req_ch.red = '0;
    req_ch.green = '0;
    req_ch.blue = '0;

    directed_rows = '{
      '{ROW_CONFIG, npc_pkg::MODE_LOAD,   8'd0, 24'h000000, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h000000, 9'd0, 1'b1, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'hff, 24'hffffff, 9'd0, 1'b1, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOAD,   8'd0, 24'h000000, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOAD,   8'd1, 24'hffffff, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOAD,   8'd2, 24'h204060, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOAD,   8'd3, 24'h204060, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_CONFIG, npc_pkg::MODE_LOAD,   8'd0, 24'h000000, 9'd1, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'hffffff, 9'd0, 1'b1, '{1'b1, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h000000, 9'd0, 1'b1, '{1'b1, 8'd0, 1'b1}},
      '{ROW_CONFIG, npc_pkg::MODE_LOAD,   8'd0, 24'h000000, 9'd4, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h204060, 9'd0, 1'b1, '{1'b1, 8'd2, 1'b1}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'hffffff, 9'd0, 1'b1, '{1'b1, 8'd1, 1'b1}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h102030, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h808080, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h214060, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOAD,   8'd3, 24'hff0000, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'hf01010, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h7f8080, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h00ff00, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   npc_pkg::MODE_LOOKUP, 8'd0, 24'h010000, 9'd0, 1'b0, '{1'b0, 8'd0, 1'b0}}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CONFIG) begin
        apply_size(row.palette_size);
      end else begin
        send_item(row.mode, row.entry_index, row.color, row.typed, row.result);
      end
    end

    // Fill every palette entry in shuffled order, with lookups mixed in.
    for (int i = 0; i < npc_pkg::PALETTE_DEPTH; i++) fill_order[i] = i;
    for (int i = npc_pkg::PALETTE_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    for (int k = 0; k < npc_pkg::PALETTE_DEPTH; k++) begin
      if ($urandom_range(0, 9) < 4) begin
        send_item(npc_pkg::MODE_LOOKUP, 8'($urandom), pick_pixel(), 1'b0, '0);
      end
      color = random_color();
      if (k > 0 && $urandom_range(0, 7) == 0) begin
        color = palette_shadow[fill_order[$urandom_range(0, k - 1)]];
      end
      send_item(npc_pkg::MODE_LOAD, 8'(fill_order[k]), color, 1'b0, '0);
    end

    phase_sizes = '{9'd256, 9'd511, 9'd1, 9'd0, 9'd2, 9'd255, 9'd384,
                    9'($urandom_range(0, 511))};
    foreach (phase_sizes[p]) begin
      apply_size(phase_sizes[p]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          send_item(npc_pkg::MODE_LOOKUP, 8'($urandom), pick_pixel(), 1'b0, '0);
        end else begin
          color = random_color();
          if ($urandom_range(0, 3) == 0) color = palette_shadow[$urandom_range(0, 255)];
          send_item(npc_pkg::MODE_LOAD, 8'($urandom), color, 1'b0, '0);
        end
      end
    end

    settle_block();
    $display("Covered %0d palette loads and %0d lookups across %0d palette_size writes.",
             load_count, lookup_count, size_writes);
    $display("Lookups hitting an exact color: %0d, against an empty palette: %0d.",
             exact_count, empty_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
